@@ design/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_FORM,
        S_SIGN,
        S_GCD,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_A,
        DP_MUL_B,
        DP_MUL_C,
        DP_MUL_D,
        DP_FORM,
        DP_SIGN,
        DP_GCD,
        DP_DIV_INIT,
        DP_DIV,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctrl;

    typedef struct packed {
        logic skip;      // zero numerator or zero denominator: no reduction
        logic gcd_done;  // one gcd operand reached zero
        logic div_last;  // final quotient bit this cycle
    } t_dp_stat;

endpackage

@@ design/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
//
// Input channel: i_valid / o_ready carry one beat holding a command (add, subtract,
// multiply, divide) and two fractions a_num/a_den and b_num/b_den. Output channel:
// o_valid / i_ready carry one beat with the result reduced to lowest terms (sign on
// the numerator), a divide-by-zero flag and the less/equal/greater compare of a vs b.
// One item is in work at a time; o_ready is high only while the sequencer is idle.
// Steps from input beat to output valid:
//   a load + 4 multiplies on the one shared multiplier + form + sign split,
//   then the binary gcd at one step per cycle (its step count set by the
//   total bit length of the two magnitudes), then a divide init and the two
//   restoring dividers running side by side, then the load of the output register.
//   A zero numerator or zero denominator skips gcd and divide.
// The output register parts the two sides: a new item is taken while a result
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds it and takes no further beat.
// Reset (synchronous, active low) empties the output register and idles the
// sequencer; no memory needs clearing.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_command,
    input  logic signed [OPERAND_WIDTH-1:0]   i_a_num,
    input  logic [OPERAND_WIDTH-2:0]          i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]   i_b_num,
    input  logic [OPERAND_WIDTH-2:0]          i_b_den,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [2*OPERAND_WIDTH:0]   o_res_num,
    output logic [2*OPERAND_WIDTH-3:0]        o_res_den,
    output logic                              o_div_by_zero,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_a_greater
);

    rau_pkg::t_dp_ctrl ctrl;
    rau_pkg::t_dp_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_a_num       (i_a_num),
        .i_a_den       (i_a_den),
        .i_b_num       (i_b_num),
        .i_b_den       (i_b_den),
        .o_res_num     (o_res_num),
        .o_res_den     (o_res_den),
        .o_div_by_zero (o_div_by_zero),
        .o_a_less      (o_a_less),
        .o_a_equal     (o_a_equal),
        .o_a_greater   (o_a_greater)
    );

    // exactly one compare outcome per delivered result
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_less, o_a_equal, o_a_greater}))
        else $error("compare flags not one-hot");

    // a zero denominator is reported as such
    a_dz_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_div_by_zero == (o_res_den == '0)))
        else $error("divide-by-zero flag disagrees with denominator");

    // an accepted beat makes the unit busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in work");

endmodule

@@ design/rau_ctrl.sv @@
// Sequencer for the rational arithmetic unit: multiply steps, gcd, divide, output.
module rau_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  rau_pkg::t_dp_stat   i_stat,
    output rau_pkg::t_dp_ctrl   o_ctrl
);

    rau_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rau_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctrl.op   = rau_pkg::DP_NOP;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.op = rau_pkg::DP_LOAD;
                    n_state   = rau_pkg::S_MUL_A;
                end
            end
            rau_pkg::S_MUL_A: begin
                o_ctrl.op = rau_pkg::DP_MUL_A;
                n_state   = rau_pkg::S_MUL_B;
            end
            rau_pkg::S_MUL_B: begin
                o_ctrl.op = rau_pkg::DP_MUL_B;
                n_state   = rau_pkg::S_MUL_C;
            end
            rau_pkg::S_MUL_C: begin
                o_ctrl.op = rau_pkg::DP_MUL_C;
                n_state   = rau_pkg::S_MUL_D;
            end
            rau_pkg::S_MUL_D: begin
                o_ctrl.op = rau_pkg::DP_MUL_D;
                n_state   = rau_pkg::S_FORM;
            end
            rau_pkg::S_FORM: begin
                o_ctrl.op = rau_pkg::DP_FORM;
                n_state   = rau_pkg::S_SIGN;
            end
            rau_pkg::S_SIGN: begin
                o_ctrl.op = rau_pkg::DP_SIGN;
                n_state   = rau_pkg::S_GCD;
            end
            rau_pkg::S_GCD: begin
                if (i_stat.skip) begin
                    n_state = rau_pkg::S_DONE;
                end else if (i_stat.gcd_done) begin
                    n_state = rau_pkg::S_DIV_INIT;
                end else begin
                    o_ctrl.op = rau_pkg::DP_GCD;
                end
            end
            rau_pkg::S_DIV_INIT: begin
                o_ctrl.op = rau_pkg::DP_DIV_INIT;
                n_state   = rau_pkg::S_DIV;
            end
            rau_pkg::S_DIV: begin
                o_ctrl.op = rau_pkg::DP_DIV;
                if (i_stat.div_last) begin
                    n_state = rau_pkg::S_DONE;
                end
            end
            rau_pkg::S_DONE: begin
                // load the output register once it is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.op   = rau_pkg::DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = rau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == rau_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ design/rau_datapath.sv @@
// Datapath: shared multiplier, sign/magnitude split, binary gcd, dual restoring divider.
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                              i_clk,
    input  rau_pkg::t_dp_ctrl                 i_ctrl,
    output rau_pkg::t_dp_stat                 o_stat,
    input  logic [1:0]                        i_command,
    input  logic signed [OPERAND_WIDTH-1:0]   i_a_num,
    input  logic [OPERAND_WIDTH-2:0]          i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]   i_b_num,
    input  logic [OPERAND_WIDTH-2:0]          i_b_den,
    output logic signed [2*OPERAND_WIDTH:0]   o_res_num,
    output logic [2*OPERAND_WIDTH-3:0]        o_res_den,
    output logic                              o_div_by_zero,
    output logic                              o_a_less,
    output logic                              o_a_equal,
    output logic                              o_a_greater
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;          // product and magnitude width
    localparam int NW = PW + 1;         // result numerator width
    localparam int DW = PW - 2;         // result denominator width
    localparam int CW = $clog2(PW);
    localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

    // operand registers
    rau_pkg::t_cmd           r_cmd;
    logic signed [W-1:0]     r_an, r_bn;
    logic [W-2:0]            r_ad, r_bd;

    // products and formed terms
    logic signed [PW-1:0]    r_cross_a, r_cross_b, r_p_dd, r_p_nn;
    logic signed [PW-1:0]    r_num, r_den;
    logic                    r_lt, r_eq, r_gt;

    // gcd / divide
    logic                    r_neg, r_dz;
    logic [PW-1:0]           r_x, r_y, r_un, r_ud, r_g;
    logic [PW-1:0]           r_rem_n, r_rem_d;
    logic [CW-1:0]           r_cnt;

    // output registers
    logic signed [NW-1:0]    r_res_num;
    logic [DW-1:0]           r_res_den;
    logic                    r_res_dz, r_res_lt, r_res_eq, r_res_gt;

    // shared multiplier
    logic signed [W:0]       mul_a, mul_b;
    logic signed [PW+1:0]    mul_p;

    logic signed [W:0]       an_x, bn_x, ad_x, bd_x;
    assign an_x = {r_an[W-1], r_an};
    assign bn_x = {r_bn[W-1], r_bn};
    assign ad_x = {2'b00, r_ad};
    assign bd_x = {2'b00, r_bd};

    always_comb begin
        case (i_ctrl.op)
            rau_pkg::DP_MUL_A: begin mul_a = an_x; mul_b = bd_x; end
            rau_pkg::DP_MUL_B: begin mul_a = ad_x; mul_b = bn_x; end
            rau_pkg::DP_MUL_C: begin mul_a = ad_x; mul_b = bd_x; end
            default:           begin mul_a = an_x; mul_b = bn_x; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // form stage
    logic signed [PW-1:0]    f_num, f_den;
    always_comb begin
        f_den = r_p_dd;
        case (r_cmd)
            rau_pkg::CMD_ADD: f_num = r_cross_a + r_cross_b;
            rau_pkg::CMD_SUB: f_num = r_cross_a - r_cross_b;
            rau_pkg::CMD_MUL: f_num = r_p_nn;
            rau_pkg::CMD_DIV: begin
                f_num = r_cross_a;
                f_den = r_cross_b;
            end
            default:          f_num = r_cross_a;
        endcase
    end

    // sign stage
    logic [PW-1:0] s_un, s_ud;
    assign s_un = r_num[PW-1] ? (~r_num + 1'b1) : r_num;
    assign s_ud = r_den[PW-1] ? (~r_den + 1'b1) : r_den;

    // gcd step: subtract and halve when both odd
    logic [PW-1:0] g_xy, g_yx;
    logic          g_xge;
    assign g_xge = (r_x >= r_y);
    assign g_xy  = r_x - r_y;
    assign g_yx  = r_y - r_x;

    // restoring divide step, both quotients share the divisor
    logic [PW:0]   d_tn, d_td, d_gx;
    logic          d_qn, d_qd;
    assign d_tn = {r_rem_n, r_un[PW-1]};
    assign d_td = {r_rem_d, r_ud[PW-1]};
    assign d_gx = {1'b0, r_g};
    assign d_qn = (d_tn >= d_gx);
    assign d_qd = (d_td >= d_gx);

    logic [NW-1:0] o_mag;
    assign o_mag = {1'b0, r_un};

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            rau_pkg::DP_LOAD: begin
                r_cmd <= rau_pkg::t_cmd'(i_command);
                r_an  <= i_a_num;
                r_ad  <= i_a_den;
                r_bn  <= i_b_num;
                r_bd  <= i_b_den;
            end
            rau_pkg::DP_MUL_A: r_cross_a <= mul_p[PW-1:0];
            rau_pkg::DP_MUL_B: r_cross_b <= mul_p[PW-1:0];
            rau_pkg::DP_MUL_C: r_p_dd    <= mul_p[PW-1:0];
            rau_pkg::DP_MUL_D: r_p_nn    <= mul_p[PW-1:0];
            rau_pkg::DP_FORM: begin
                r_num <= f_num;
                r_den <= f_den;
                r_lt  <= (r_cross_a <  r_cross_b);
                r_eq  <= (r_cross_a == r_cross_b);
                r_gt  <= (r_cross_a >  r_cross_b);
            end
            rau_pkg::DP_SIGN: begin
                r_neg <= (r_num[PW-1] != r_den[PW-1]) && (r_num != '0);
                r_dz  <= (s_ud == '0);
                r_un  <= s_un;
                r_ud  <= s_ud;
                r_x   <= s_un;
                r_y   <= s_ud;
            end
            rau_pkg::DP_GCD: begin
                if (!r_x[0] && !r_y[0]) begin
                    // common factor of two: strip it from the dividends as well
                    r_x  <= r_x >> 1;
                    r_y  <= r_y >> 1;
                    r_un <= r_un >> 1;
                    r_ud <= r_ud >> 1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (g_xge) begin
                    r_x <= g_xy >> 1;
                end else begin
                    r_y <= g_yx >> 1;
                end
            end
            rau_pkg::DP_DIV_INIT: begin
                r_g     <= r_x | r_y;
                r_rem_n <= '0;
                r_rem_d <= '0;
                r_cnt   <= '0;
            end
            rau_pkg::DP_DIV: begin
                r_rem_n <= d_qn ? PW'(d_tn - d_gx) : d_tn[PW-1:0];
                r_rem_d <= d_qd ? PW'(d_td - d_gx) : d_td[PW-1:0];
                r_un    <= {r_un[PW-2:0], d_qn};
                r_ud    <= {r_ud[PW-2:0], d_qd};
                r_cnt   <= r_cnt + 1'b1;
            end
            rau_pkg::DP_OUT: begin
                r_res_num <= r_neg ? (~o_mag + 1'b1) : o_mag;
                r_res_den <= r_ud[DW-1:0];
                r_res_dz  <= r_dz;
                r_res_lt  <= r_lt;
                r_res_eq  <= r_eq;
                r_res_gt  <= r_gt;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.skip     = (r_un == '0) || r_dz;
    assign o_stat.gcd_done = (r_x == '0) || (r_y == '0);
    assign o_stat.div_last = (r_cnt == DIV_LAST);

    assign o_res_num     = r_res_num;
    assign o_res_den     = r_res_den;
    assign o_div_by_zero = r_res_dz;
    assign o_a_less      = r_res_lt;
    assign o_a_equal     = r_res_eq;
    assign o_a_greater   = r_res_gt;

endmodule

@@ bench/rational_arithmetic_unit_test.sv @@
// Self-checking bench for the rational arithmetic unit: fraction ops, reduction, compare.
module rational_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = rau_pkg::OPERAND_WIDTH;

    // The drain wait covers one more item in flight plus the output register.
    localparam int DRAIN_CYCLES = 250;

    // Watchdog limit for about 1550 items, random stalls and one long hold-off.
    localparam int CYCLE_LIMIT = 1_500_000;

    // Expected content of one result beat.
    typedef struct packed {
        logic [2*W:0]   num;
        logic [2*W-3:0] den;
        logic           div_by_zero;
        logic           a_less;
        logic           a_equal;
        logic           a_greater;
    } t_fraction_result;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                op_valid = 1'b0;
    logic                op_ready;
    logic [1:0]          op_cmd   = rau_pkg::CMD_ADD;
    logic signed [W-1:0] op_a_num = '0;
    logic [W-2:0]        op_a_den = '0;
    logic signed [W-1:0] op_b_num = '0;
    logic [W-2:0]        op_b_den = '0;

    logic                res_valid;
    logic                res_ready = 1'b0;
    logic signed [2*W:0] res_num;
    logic [2*W-3:0]      res_den;
    logic                res_div_by_zero;
    logic                res_a_less;
    logic                res_a_equal;
    logic                res_a_greater;

    always #1 clk = ~clk;

    rational_arithmetic_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (op_valid),
        .o_ready       (op_ready),
        .i_command     (op_cmd),
        .i_a_num       (op_a_num),
        .i_a_den       (op_a_den),
        .i_b_num       (op_b_num),
        .i_b_den       (op_b_den),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_res_num     (res_num),
        .o_res_den     (res_den),
        .o_div_by_zero (res_div_by_zero),
        .o_a_less      (res_a_less),
        .o_a_equal     (res_a_equal),
        .o_a_greater   (res_a_greater)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_fraction_result pending_results[$];   // predictions, oldest first
    int  failures       = 0;
    int  results_seen   = 0;
    int  zero_div_seen  = 0;
    int  ops_per_cmd[4] = '{0, 0, 0, 0};
    int  cycle_count    = 0;

    bit  send_gaps      = 1'b1;   // sender idles ~33% of cycles when set
    bit  recv_stalls    = 1'b1;   // receiver idles ~33% of cycles when set
    int  hold_left      = 0;      // receiver hold-off, in cycles

    // ------------------------------------------------------------------
    // Predictor: cross-multiply, move the sign onto the numerator, reduce by
    // the gcd of the magnitudes unless the numerator or denominator is zero.
    // ------------------------------------------------------------------
    function automatic longint unsigned common_divisor(longint unsigned x,
                                                       longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction_result reduce_fraction(rau_pkg::t_cmd cmd,
                                                         logic [W-1:0] a_num_bits,
                                                         logic [W-2:0] a_den_bits,
                                                         logic [W-1:0] b_num_bits,
                                                         logic [W-2:0] b_den_bits);
        longint           an, ad, bn, bd;
        longint           cross_a, cross_b, num, den;
        longint unsigned  num_mag, den_mag, g, signed_num;
        bit               negative;
        t_fraction_result r;
        an = longint'($signed(a_num_bits));
        bn = longint'($signed(b_num_bits));
        ad = longint'(a_den_bits);
        bd = longint'(b_den_bits);
        cross_a = an * bd;
        cross_b = ad * bn;
        case (cmd)
            rau_pkg::CMD_ADD: begin num = cross_a + cross_b; den = ad * bd; end
            rau_pkg::CMD_SUB: begin num = cross_a - cross_b; den = ad * bd; end
            rau_pkg::CMD_MUL: begin num = an * bn;           den = ad * bd; end
            default:          begin num = cross_a;           den = cross_b; end
        endcase
        // a negative denominator hands its sign to the numerator
        negative = (num < 0) != (den < 0);
        num_mag  = (num < 0) ? longint'(-num) : num;
        den_mag  = (den < 0) ? longint'(-den) : den;
        if (num == 0)
            negative = 1'b0;
        r.div_by_zero = (den_mag == 0);
        // zero numerator stays unreduced, as does a zero denominator
        if (den_mag != 0 && num_mag != 0) begin
            g = common_divisor(num_mag, den_mag);
            num_mag = num_mag / g;
            den_mag = den_mag / g;
        end
        signed_num  = negative ? -num_mag : num_mag;
        r.num       = signed_num[2*W:0];
        r.den       = den_mag[2*W-3:0];
        r.a_less    = (cross_a < cross_b);
        r.a_equal   = (cross_a == cross_b);
        r.a_greater = (cross_a > cross_b);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Failure log: the first ten are printed, the rest only counted.
    // ------------------------------------------------------------------
    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Cycle counter and watchdog.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_results.size());
        $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side: every accepted beat gets its prediction queued. Sampled at
    // the rising edge, so values are the ones the block itself sees.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : capture_operations
        if (rst_n && op_valid && op_ready) begin
            pending_results.push_back(reduce_fraction(rau_pkg::t_cmd'(op_cmd),
                                                      op_a_num, op_a_den,
                                                      op_b_num, op_b_den));
            ops_per_cmd[op_cmd]++;
        end
    end

    // ------------------------------------------------------------------
    // Output side: each accepted result beat against the oldest prediction,
    // field by field.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        t_fraction_result got;
        t_fraction_result want;
        string            diff;
        if (rst_n && res_valid && res_ready) begin
            got = '{res_num, res_den, res_div_by_zero, res_a_less, res_a_equal,
                    res_a_greater};
            results_seen++;
            if (got.div_by_zero)
                zero_div_seen++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result num=%0d den=%0d",
                                       $signed(got.num), got.den));
            end else begin
                want = pending_results.pop_front();
                diff = "";
                if (got.num !== want.num)                 diff = {diff, " res_num"};
                if (got.den !== want.den)                 diff = {diff, " res_den"};
                if (got.div_by_zero !== want.div_by_zero) diff = {diff, " div_by_zero"};
                if (got.a_less !== want.a_less)           diff = {diff, " a_less"};
                if (got.a_equal !== want.a_equal)         diff = {diff, " a_equal"};
                if (got.a_greater !== want.a_greater)     diff = {diff, " a_greater"};
                if (diff != "")
                    note_failure({
                        $sformatf("result %0d [%s ]: want %0d/%0d dz=%b lt/eq/gt=%b%b%b",
                                  results_seen, diff,
                                  $signed(want.num), want.den, want.div_by_zero,
                                  want.a_less, want.a_equal, want.a_greater),
                        $sformatf(", got %0d/%0d dz=%b lt/eq/gt=%b%b%b",
                                  $signed(got.num), got.den, got.div_by_zero,
                                  got.a_less, got.a_equal, got.a_greater)});
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drives ready at the falling edge. A hold-off counts down here;
    // otherwise ready is random or held high depending on the phase.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive_result_ready
        if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (recv_stalls) begin
            res_ready <= ($urandom_range(99) >= 33);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at the falling edge after the
    // beat is taken. Valid is only lowered when a gap is inserted, so it gets
    // a single update per edge even for back-to-back beats.
    // ------------------------------------------------------------------
    task automatic send_operation(rau_pkg::t_cmd cmd, logic [W-1:0] a_num,
                                  logic [W-2:0] a_den, logic [W-1:0] b_num,
                                  logic [W-2:0] b_den);
        while (send_gaps && $urandom_range(99) < 33) begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        op_cmd   <= cmd;
        op_a_num <= a_num;
        op_a_den <= a_den;
        op_b_num <= b_num;
        op_b_den <= b_den;
        op_valid <= 1'b1;
        @(posedge clk);
        while (!op_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Field pickers: extremes weighted in, otherwise the full field.
    function automatic logic [W-1:0] pick_numerator();
        case ($urandom_range(11))
            0:       return {1'b1, {(W-1){1'b0}}};   // most negative
            1:       return {1'b0, {(W-1){1'b1}}};   // most positive
            2:       return '0;
            3:       return '1;                      // -1
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [W-2:0] pick_denominator();
        case ($urandom_range(19))
            0:       return '0;                      // out-of-range zero
            1:       return '1;
            2:       return (W-1)'(1);
            default: return (W-1)'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked beats: every command, field extremes, sign handling and the
    // zero numerator / zero denominator paths.
    task automatic test_directed();
        localparam logic [W-1:0] NUM_MIN = {1'b1, {(W-1){1'b0}}};
        localparam logic [W-1:0] NUM_MAX = {1'b0, {(W-1){1'b1}}};
        localparam logic [W-2:0] DEN_MAX = '1;
        // plain reduce-free sum
        send_operation(rau_pkg::CMD_ADD, W'(1), (W-1)'(2), W'(1), (W-1)'(3));
        // 32/16 reduces to 2/1
        send_operation(rau_pkg::CMD_ADD, W'(6), (W-1)'(4), W'(2), (W-1)'(4));
        // zero numerator, unreduced
        send_operation(rau_pkg::CMD_SUB, W'(1), (W-1)'(2), W'(1), (W-1)'(2));
        // widest difference
        send_operation(rau_pkg::CMD_SUB, NUM_MAX, (W-1)'(1), NUM_MIN, (W-1)'(1));
        send_operation(rau_pkg::CMD_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
        send_operation(rau_pkg::CMD_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
        // largest product
        send_operation(rau_pkg::CMD_MUL, NUM_MIN, (W-1)'(1), NUM_MIN, (W-1)'(1));
        send_operation(rau_pkg::CMD_MUL, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
        // zero times anything
        send_operation(rau_pkg::CMD_MUL, '0, (W-1)'(7), NUM_MIN, (W-1)'(3));
        // -1 * -1
        send_operation(rau_pkg::CMD_MUL, '1, (W-1)'(1), '1, (W-1)'(1));
        // divide by zero fraction
        send_operation(rau_pkg::CMD_DIV, NUM_MAX, (W-1)'(1), '0, (W-1)'(1));
        // 0 / 0
        send_operation(rau_pkg::CMD_DIV, '0, (W-1)'(1), '0, (W-1)'(1));
        // negative divisor
        send_operation(rau_pkg::CMD_DIV, W'(3), (W-1)'(4), W'(-6), (W-1)'(8));
        // divide by -1
        send_operation(rau_pkg::CMD_DIV, W'(5), (W-1)'(1), '1, (W-1)'(1));
        send_operation(rau_pkg::CMD_DIV, NUM_MIN, DEN_MAX, NUM_MIN, (W-1)'(1));
        // zero dividend
        send_operation(rau_pkg::CMD_DIV, '0, (W-1)'(5), W'(3), (W-1)'(7));
        // zero a denominator
        send_operation(rau_pkg::CMD_ADD, W'(3), '0, W'(2), (W-1)'(5));
        // zero b denominator
        send_operation(rau_pkg::CMD_SUB, W'(3), (W-1)'(4), W'(2), '0);
        // both denominators zero
        send_operation(rau_pkg::CMD_MUL, NUM_MAX, '0, NUM_MIN, '0);
        // compare with zero dens
        send_operation(rau_pkg::CMD_DIV, W'(4), '0, W'(-2), '0);
        send_operation(rau_pkg::CMD_SUB, NUM_MIN, (W-1)'(1), NUM_MAX, DEN_MAX);
    endtask

    // Full-range random beats, with gaps on both sides while send_gaps and recv_stalls are set.
    task automatic test_random_fractions(int count);
        repeat (count)
            send_operation(rau_pkg::t_cmd'($urandom_range(3)), pick_numerator(),
                           pick_denominator(), pick_numerator(), pick_denominator());
    endtask

    // Small operands sharing factors, so reduction actually has work to do.
    task automatic test_common_factors(int count);
        int k;
        repeat (count) begin
            k = $urandom_range(1, 12);
            send_operation(rau_pkg::t_cmd'($urandom_range(3)),
                           W'(k * ($urandom_range(0, 40) - 20)),
                           (W-1)'(k * $urandom_range(1, 30)),
                           W'(k * ($urandom_range(0, 40) - 20)),
                           (W-1)'(k * $urandom_range(1, 30)));
        end
    endtask

    // Back-to-back stretch: no idling on either side.
    task automatic test_full_rate(int count);
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_random_fractions(count);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // Receiver holds off for a long stretch while beats keep coming: the output
    // register fills, the sequencer holds its next result and input stalls.
    task automatic test_result_backpressure(int count);
        send_gaps = 1'b0;
        hold_left = 600;
        test_random_fractions(count);
        send_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_fractions(700);
        test_full_rate(300);
        test_result_backpressure(16);
        test_common_factors(500);

        op_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats in (add %0d, sub %0d, mul %0d, div %0d), %0d results checked",
                 ops_per_cmd[rau_pkg::CMD_ADD] + ops_per_cmd[rau_pkg::CMD_SUB]
                 + ops_per_cmd[rau_pkg::CMD_MUL] + ops_per_cmd[rau_pkg::CMD_DIV],
                 ops_per_cmd[rau_pkg::CMD_ADD], ops_per_cmd[rau_pkg::CMD_SUB],
                 ops_per_cmd[rau_pkg::CMD_MUL], ops_per_cmd[rau_pkg::CMD_DIV],
                 results_seen);
        $display("%0d divide-by-zero results, %0d failures, %0d cycles",
                 zero_div_seen, failures, cycle_count);
        if (failures == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/rau_pkg.sv
design/rau_ctrl.sv
design/rau_datapath.sv
design/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_test.sv
